// File: rtl/sbb_pkg.sv
// Package for the separable box blur core: sizes, state machine type,
// controller/datapath command and status structs. No dependencies.
package sbb_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_KERNEL = 31;
  localparam int COL_W  = $clog2(MAX_WIDTH);       // 11
  localparam int ROW_W  = $clog2(MAX_HEIGHT) + 1;  // 13
  localparam int KW     = $clog2(MAX_KERNEL + 1);  // 5
  localparam int SLOT_W = $clog2(MAX_KERNEL);      // 5
  localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int LS_AW  = $clog2(LS_DEPTH);
  localparam int SUM_W  = 8 + KW;                  // up to 31*255
  localparam int PADDR_W = 5;

  localparam logic [PADDR_W-1:0] REG_IMAGE_WIDTH   = 5'd0;
  localparam logic [PADDR_W-1:0] REG_IMAGE_HEIGHT  = 5'd4;
  localparam logic [PADDR_W-1:0] REG_KERNEL_WIDTH  = 5'd8;
  localparam logic [PADDR_W-1:0] REG_KERNEL_HEIGHT = 5'd12;
  localparam logic [PADDR_W-1:0] REG_COLOR_MODE    = 5'd16;

  typedef enum logic [3:0] {
    ST_IDLE,    // wait for an item
    ST_HRD,     // write pixel into raw row, clear tap counter
    ST_HACC,    // accumulate horizontal tap
    ST_HDIV,    // divide horizontal sums
    ST_HWR,     // write horizontal result to line store
    ST_VRD,     // issue line store read for vertical tap k
    ST_VACC,    // accumulate vertical tap
    ST_VDIV,    // divide vertical sums
    ST_OUT,     // present result
    ST_NEXT     // advance column or finish
  } state_t;

  typedef struct packed {
    logic start;       // latch item, compute geometry
    logic raw_write;   // write pixel into raw row
    logic clr_acc;
    logic hrd;         // raw row read at tap k
    logic acc;         // add registered read data
    logic div_start;
    logic hwr;         // write horizontal result
    logic vrd;         // line store read at tap k
    logic load_out;
    logic next_x;
    logic finish;      // update counters
    logic use_ls;      // accumulate from line store read data
  } cmd_t;

  typedef struct packed {
    logic ignore;      // drain item inside image
    logic real_row;    // r < h
    logic do_h;        // range non-empty
    logic do_v;        // output row valid
    logic k_last;      // tap counter at last tap
    logic x_last;      // x at x1
    logic div_done;
  } sts_t;

  // round(s/d), ties to even, from quotient and remainder
  function automatic logic [7:0] round_even(input logic [SUM_W-1:0] q,
                                            input logic [KW:0] rem2,
                                            input logic [KW-1:0] d);
    logic up;
    up = (rem2 > {1'b0, d}) || (rem2 == {1'b0, d} && q[0]);
    return q[7:0] + {7'd0, up};
  endfunction

  // row modulo MAX_KERNEL (31): 32 = 1 mod 31, so fold 5-bit digits
  function automatic logic [SLOT_W-1:0] mod_kernel(input logic [ROW_W-1:0] v);
    logic [6:0] s1;
    logic [5:0] s2;
    s1 = 7'(v[4:0]) + 7'(v[9:5]) + 7'(v[12:10]);
    s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
    if (s2 >= 6'd31) s2 = s2 - 6'd31;
    return s2[4:0];
  endfunction
endpackage

// File: rtl/sbb_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/sbb_ctrl.sv
// Controller state machine for the box blur core.
// Depends on sbb_pkg.
module sbb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sbb_pkg::sts_t   sts,
  output sbb_pkg::cmd_t   cmd
);
  import sbb_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = ST_HRD;
        end
      end
      ST_HRD: begin
        // first cycle after start: geometry settled
        if (sts.ignore) state_next = ST_IDLE;
        else begin
          cmd.raw_write = sts.real_row;
          if (!sts.do_h) state_next = ST_NEXT;
          else begin
            cmd.clr_acc = 1'b1;
            state_next = sts.real_row ? ST_HACC : ST_VRD;
          end
        end
      end
      ST_HACC: begin
        cmd.hrd = 1'b1;
        if (sts.k_last) state_next = ST_HDIV;
      end
      ST_HDIV: begin
        cmd.acc = 1'b1;  // last read data
        cmd.div_start = 1'b1;
        state_next = ST_HWR;
      end
      ST_HWR: begin
        if (sts.div_done) begin
          cmd.hwr = 1'b1;
          cmd.clr_acc = 1'b1;
          state_next = ST_VRD;
        end
      end
      ST_VRD: begin
        if (!sts.do_v) state_next = ST_NEXT;
        else begin
          cmd.vrd = 1'b1;
          cmd.use_ls = 1'b1;
          if (sts.k_last) state_next = ST_VACC;
        end
      end
      ST_VACC: begin
        cmd.use_ls = 1'b1;
        cmd.acc = 1'b1;
        cmd.div_start = 1'b1;
        state_next = ST_VDIV;
      end
      ST_VDIV: begin
        cmd.use_ls = 1'b1;
        if (sts.div_done) begin
          cmd.load_out = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (sts.do_h && !sts.x_last) begin
          cmd.next_x = 1'b1;
          cmd.clr_acc = 1'b1;
          state_next = sts.real_row ? ST_HACC : ST_VRD;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/sbb_dp.sv
// Datapath: counters, raw row and line store RAMs, tap accumulators,
// serial divider, output register. Depends on sbb_pkg and sbb_ram.
module sbb_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sbb_pkg::cmd_t         cmd,
  output sbb_pkg::sts_t         sts,
  input  logic [11:0]           image_width,
  input  logic [12:0]           image_height,
  input  logic [4:0]            kernel_width,
  input  logic [4:0]            kernel_height,
  input  logic                  color_mode,
  input  logic                  action,
  input  logic [7:0]            in_ch0,
  input  logic [7:0]            in_ch1,
  input  logic [7:0]            in_ch2,
  output logic [7:0]            out_ch0,
  output logic [7:0]            out_ch1,
  output logic [7:0]            out_ch2,
  output logic                  last_of_run,
  output logic                  frame_done
);
  import sbb_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  wm1, c, x, x1;
  logic [ROW_W-1:0]  h, hm1, y;
  logic [KW-1:0]     kw, kh, lw, rw, uh, dh, k;
  logic              drain, cm;
  logic [23:0]       px;
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum [3];
  logic [23:0]       res;

  // register geometry: clamp as the spec requires
  always_comb begin
    wm1 = (image_width == 12'd0) ? '0 :
          (image_width > 12'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1) :
          COL_W'(image_width - 12'd1);
    h   = (image_height == 13'd0) ? ROW_W'(1) :
          (image_height > 13'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : image_height;
    hm1 = h - ROW_W'(1);
    kw  = (kernel_width == 5'd0) ? 5'd1 : kernel_width;
    kh  = (kernel_height == 5'd0) ? 5'd1 : kernel_height;
    lw  = kw >> 1;
    rw  = kw - 5'd1 - lw;
    uh  = kh >> 1;
    dh  = kh - 5'd1 - uh;
  end

  logic [COL_W-1:0] c_now;
  assign c_now = (column_count > wm1) ? wm1 : column_count;

  // per-item latched state
  logic real_row, do_h, ignore, do_v;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      drain <= action;
      cm    <= color_mode;
      c     <= c_now;
      px    <= {in_ch2, in_ch1, in_ch0};
      slot  <= mod_kernel(row_count);
      y     <= row_count - ROW_W'(dh);
      if (c_now < wm1) begin
        x  <= c_now - COL_W'(rw);
        x1 <= c_now - COL_W'(rw);
      end else begin
        x  <= (wm1 >= COL_W'(rw)) ? wm1 - COL_W'(rw) : '0;
        x1 <= wm1;
      end
    end else if (cmd.next_x) begin
      x <= x + COL_W'(1);
    end
  end

  assign real_row = row_count < h;
  assign ignore   = real_row && drain;
  assign do_h     = (c >= wm1) || (c >= COL_W'(rw));
  assign do_v     = (row_count >= ROW_W'(dh)) && (y < h);
  assign sts.ignore   = ignore;
  assign sts.real_row = real_row;
  assign sts.do_h     = do_h;
  assign sts.do_v     = do_v;
  assign sts.x_last   = (x == x1);

  // tap counter
  always_ff @(posedge clk) begin
    if (cmd.clr_acc) k <= '0;
    else if (cmd.hrd || cmd.vrd) k <= k + 5'd1;
  end
  assign sts.k_last = cmd.use_ls ? (k == kh - 5'd1) : (k == kw - 5'd1);

  // raw row RAM
  logic [COL_W:0]   hcol_s;
  logic [COL_W-1:0] raw_addr;
  logic [23:0]      raw_rd;
  assign hcol_s = {1'b0, x} + {{(COL_W-4){1'b0}}, k} - {{(COL_W-4){1'b0}}, lw};
  always_comb begin
    if (cmd.raw_write) raw_addr = c;
    else if ({1'b0, x} + {{(COL_W-4){1'b0}}, k} < {{(COL_W-4){1'b0}}, lw}) raw_addr = '0;
    else if (hcol_s[COL_W-1:0] > wm1 || hcol_s[COL_W]) raw_addr = wm1;
    else raw_addr = hcol_s[COL_W-1:0];
  end
  sbb_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_raw (
    .clk(clk), .we(cmd.raw_write), .addr(raw_addr),
    .wdata(cm ? px : {16'd0, px[7:0]}), .rdata(raw_rd));

  // line store RAM: slot*MAX_WIDTH + x
  logic [ROW_W:0]    vj;
  logic [ROW_W-1:0]  vrow;
  logic [SLOT_W-1:0] vslot;
  logic [LS_AW-1:0]  ls_addr;
  logic [23:0]       ls_rd;
  always_comb begin
    vj = {1'b0, y} + {{(ROW_W-4){1'b0}}, k};
    if (vj < {{(ROW_W-4){1'b0}}, uh}) vrow = '0;
    else if (vj - {{(ROW_W-4){1'b0}}, uh} > {1'b0, hm1}) vrow = hm1;
    else vrow = ROW_W'(vj - {{(ROW_W-4){1'b0}}, uh});
    vslot = mod_kernel(vrow);
    ls_addr = cmd.hwr ? LS_AW'(slot * MAX_WIDTH + x) : LS_AW'(vslot * MAX_WIDTH + x);
  end
  sbb_ram #(.WIDTH(24), .DEPTH(LS_DEPTH)) u_ls (
    .clk(clk), .we(cmd.hwr), .addr(ls_addr), .wdata(res), .rdata(ls_rd));

  // accumulate the data read in the previous cycle
  logic acc_pend;
  logic [23:0] acc_src;
  always_ff @(posedge clk) begin
    if (rst) acc_pend <= 1'b0;
    else acc_pend <= cmd.hrd || cmd.vrd;
  end
  assign acc_src = cmd.use_ls ? ls_rd : raw_rd;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.clr_acc) sum[i] <= '0;
      else if (acc_pend) sum[i] <= sum[i] + SUM_W'(acc_src[8*i +: 8]);
    end
  end

  // restoring divider, one quotient bit per cycle, three channels at once
  logic [SUM_W-1:0] q [3];
  logic [KW:0]      rm [3];
  logic [3:0]       dcnt;
  logic             dbusy;
  logic [KW-1:0]    dv;
  assign dv = cmd.use_ls ? kh : kw;
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dcnt  <= 4'(SUM_W - 1);
    end else if (dbusy) begin
      if (dcnt == 4'd0) dbusy <= 1'b0;
      else dcnt <= dcnt - 4'd1;
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_start) begin
        q[i]  <= (acc_pend) ? sum[i] + SUM_W'(acc_src[8*i +: 8]) : sum[i];
        rm[i] <= '0;
      end else if (dbusy) begin
        if ({rm[i][KW-1:0], q[i][SUM_W-1]} >= {1'b0, dv}) begin
          rm[i] <= {rm[i][KW-1:0], q[i][SUM_W-1]} - {1'b0, dv};
          q[i]  <= {q[i][SUM_W-2:0], 1'b1};
        end else begin
          rm[i] <= {rm[i][KW-1:0], q[i][SUM_W-1]};
          q[i]  <= {q[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end
  assign sts.div_done = !dbusy && !cmd.div_start;
  always_comb begin
    for (int i = 0; i < 3; i++)
      res[8*i +: 8] = round_even(q[i], {rm[i][KW-1:0], 1'b0}, dv);
  end

  // output register and counters
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch0     <= res[7:0];
      out_ch1     <= cm ? res[15:8] : 8'd0;
      out_ch2     <= cm ? res[23:16] : 8'd0;
      last_of_run <= (x == x1);
      frame_done  <= (x == wm1) && (y == hm1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.finish) begin
      if (c >= wm1) begin
        column_count <= '0;
        if (row_count >= hm1 + ROW_W'(dh)) row_count <= '0;
        else row_count <= row_count + ROW_W'(1);
      end else begin
        column_count <= c + COL_W'(1);
      end
    end
  end
endmodule

// File: rtl/separable_box_blur_core.sv
// Separable box blur core, one transaction in flight. Each result is paced
// by the serial tap reads and the 13-step bit-serial divider, and no new
// input is accepted until every result of the last one has been taken.
// An input may cause up to 16 results. Synchronous active-high reset clears
// counters and control and restores register defaults; line store undefined.
module separable_box_blur_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  in_ch0,
  input  logic [7:0]  in_ch1,
  input  logic [7:0]  in_ch2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic        last_of_run,
  output logic        frame_done
);
  import sbb_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [4:0]  kernel_width, kernel_height;
  logic        color_mode;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  // register writes complete in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd640;
      image_height  <= 13'd480;
      kernel_width  <= 5'd3;
      kernel_height <= 5'd3;
      color_mode    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_IMAGE_WIDTH:   image_width   <= pwdata[11:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[12:0];
        REG_KERNEL_WIDTH:  kernel_width  <= pwdata[4:0];
        REG_KERNEL_HEIGHT: kernel_height <= pwdata[4:0];
        REG_COLOR_MODE:    color_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      REG_IMAGE_WIDTH:   prdata = {20'd0, image_width};
      REG_IMAGE_HEIGHT:  prdata = {19'd0, image_height};
      REG_KERNEL_WIDTH:  prdata = {27'd0, kernel_width};
      REG_KERNEL_HEIGHT: prdata = {27'd0, kernel_height};
      REG_COLOR_MODE:    prdata = {31'd0, color_mode};
      default:           prdata = 32'd0;
    endcase
  end

  sbb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

  sbb_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .image_width(image_width), .image_height(image_height),
    .kernel_width(kernel_width), .kernel_height(kernel_height),
    .color_mode(color_mode), .action(action),
    .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2),
    .last_of_run(last_of_run), .frame_done(frame_done));

  // one transaction in flight: never accept while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("accept during output");
  // a finished result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ch0))
    else $error("result dropped");
  // in gray mode upper channels read zero
  a_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid && !color_mode && $stable(color_mode) |-> out_ch1 == 8'd0 || $past(color_mode))
    else $error("gray channel not zero");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for separable_box_blur_core: framed pixel streams
// with random handshake gaps, checked against an in-bench box filter model.
// Depends on sbb_pkg (register addresses, sizes) and the core itself.
module tb_top;
  import sbb_pkg::*;

  // one filtered pixel as it leaves the core
  typedef struct {
    logic [7:0] ch0, ch1, ch2;
    logic       last, done;
  } blur_px_t;

  // Box filter predictor: shadow registers, raw row, line store, counters.
  class blur_scoreboard;
    bit [23:0]   raw_row[MAX_WIDTH];
    bit [23:0]   line_store[LS_DEPTH];
    int unsigned col_cnt, row_cnt;
    bit [11:0]   img_w;
    bit [12:0]   img_h;
    bit [4:0]    ker_w, ker_h;
    bit          bgr;
    blur_px_t    pending[$];
    int          errors;

    function new();
      img_w = 640; img_h = 480; ker_w = 3; ker_h = 3; bgr = 0;
    endfunction

    function void set_reg(logic [PADDR_W-1:0] addr, logic [31:0] val);
      case (addr)
        REG_IMAGE_WIDTH:   img_w = val[11:0];
        REG_IMAGE_HEIGHT:  img_h = val[12:0];
        REG_KERNEL_WIDTH:  ker_w = val[4:0];
        REG_KERNEL_HEIGHT: ker_h = val[4:0];
        REG_COLOR_MODE:    bgr   = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned clampu(int unsigned v, int unsigned hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
    endfunction
    function int unsigned eff_w(); return clampu(img_w, MAX_WIDTH); endfunction
    function int unsigned eff_h(); return clampu(img_h, MAX_HEIGHT); endfunction
    function int unsigned below_rows();  // rows of lag in the vertical pass
      int unsigned kh;
      kh = clampu(ker_h, MAX_KERNEL);
      return kh - 1 - kh / 2;
    endfunction

    // per-channel mean, round half to even
    function bit [23:0] box_mean(bit [23:0] win[MAX_KERNEL], int unsigned n);
      bit [23:0] res;
      int unsigned s, q, rm;
      res = 0;
      for (int ch = 0; ch < 3; ch++) begin
        s = 0;
        for (int i = 0; i < n; i++) s += (win[i] >> (8 * ch)) & 8'hFF;
        q = s / n;
        rm = s % n;
        if (rm * 2 > n || (rm * 2 == n && q[0])) q++;
        res |= (q & 8'hFF) << (8 * ch);
      end
      return res;
    endfunction

    // accepted input transaction: advance the model, queue its results
    function void note_input(bit drain, logic [7:0] c0, c1, c2);
      int unsigned w, h, kw, kh, lw, rw, uh, dh, r, c, slot, x0, x1, y;
      int          col, j;
      bit [23:0]   win[MAX_KERNEL];
      bit [23:0]   v;
      blur_px_t    px;
      int          n;
      w = eff_w(); h = eff_h();
      kw = clampu(ker_w, MAX_KERNEL); kh = clampu(ker_h, MAX_KERNEL);
      lw = kw / 2; rw = kw - 1 - kw / 2;
      uh = kh / 2; dh = kh - 1 - kh / 2;
      r = row_cnt;
      c = col_cnt > w - 1 ? w - 1 : col_cnt;
      slot = (r % MAX_KERNEL) * MAX_WIDTH;
      n = 0;
      if (r < h) begin
        if (drain) return;  // drain inside the image is dropped
        raw_row[c] = bgr ? {c2, c1, c0} : {16'd0, c0};
      end
      x0 = 1; x1 = 0;
      if (c < w - 1) begin
        if (c >= rw) begin x0 = c - rw; x1 = x0; end
      end else begin
        x0 = (w - 1 >= rw) ? w - 1 - rw : 0;
        x1 = w - 1;
      end
      if (x0 <= x1) begin
        for (int unsigned x = x0; x <= x1; x++) begin
          if (r < h) begin
            for (int k = 0; k < kw; k++) begin
              col = int'(x) - int'(lw) + k;
              if (col < 0) col = 0;
              if (col > int'(w) - 1) col = w - 1;
              win[k] = raw_row[col];
            end
            line_store[slot + x] = box_mean(win, kw);
          end
          if (r >= dh && r - dh < h) begin
            y = r - dh;
            for (int k = 0; k < kh; k++) begin
              j = int'(y) - int'(uh) + k;
              if (j < 0) j = 0;
              if (j > int'(h) - 1) j = h - 1;
              win[k] = line_store[(j % MAX_KERNEL) * MAX_WIDTH + x];
            end
            v = box_mean(win, kh);
            px.ch0 = v[7:0];
            px.ch1 = bgr ? v[15:8] : 8'd0;
            px.ch2 = bgr ? v[23:16] : 8'd0;
            px.last = 0;
            px.done = (x == w - 1 && y == h - 1);
            pending.push_back(px);
            n++;
          end
        end
      end
      if (n > 0) pending[$].last = 1;
      if (c >= w - 1) begin
        col_cnt = 0;
        row_cnt = (r >= h - 1 + dh) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(blur_px_t got);
      blur_px_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected ch0=%0d", got.ch0));
        return;
      end
      want = pending.pop_front();
      if (got.ch0 !== want.ch0) report($sformatf("ch0 %0d want %0d", got.ch0, want.ch0));
      if (got.ch1 !== want.ch1) report($sformatf("ch1 %0d want %0d", got.ch1, want.ch1));
      if (got.ch2 !== want.ch2) report($sformatf("ch2 %0d want %0d", got.ch2, want.ch2));
      if (got.last !== want.last) report($sformatf("last_of_run %b want %b", got.last, want.last));
      if (got.done !== want.done) report($sformatf("frame_done %b want %b", got.done, want.done));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic        action = 0;
  logic [7:0]  in_ch0 = 0, in_ch1 = 0, in_ch2 = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  out_ch0, out_ch1, out_ch2;
  logic        last_of_run, frame_done;

  separable_box_blur_core u_dut (.*);

  blur_scoreboard sb = new();
  bit gaps_on = 1;      // random idling on both sides
  bit hold_req = 0;     // ask the receiver for one long hold-off
  int random_items = 0;

  initial forever #2 clk = ~clk;

  // Generous fixed limit; the slowest legal run is well under a tenth of this.
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: checks every accepted result, then decides ready for next edge.
  initial begin
    int stall_left, hold_left;
    blur_px_t got;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.ch0 = out_ch0; got.ch1 = out_ch1; got.ch2 = out_ch2;
        got.last = last_of_run; got.done = frame_done;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (hold_req) begin
        // long back-pressure so the core holds its result and stalls its input
        hold_req = 0;
        hold_left = 400;
        out_ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // APB write: setup then access, register takes the value on the access edge
  task write_reg(logic [PADDR_W-1:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(addr, val);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait for all expected results, then let any trailing work finish
  task wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task configure(int w, int h, int kw, int kh, int cm);
    in_valid <= 0;  // nothing more offered until the new settings are in
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_COLOR_MODE, cm);
  endtask

  // one input transaction, with an optional idle burst ahead of it
  task send_item(bit drain, logic [7:0] c0, c1, c2);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    action <= drain; in_ch0 <= c0; in_ch1 <= c1; in_ch2 <= c2;
    do @(posedge clk); while (!in_ready);
    sb.note_input(drain, c0, c1, c2);
  endtask

  // Whole frame under the current settings. Real pixels in the image rows,
  // with stray drain transactions mixed in (the core drops those); below the
  // image both drains and real pixels are sent, the latter acting as drains.
  // extremes: pixel values pinned to 0 and 255 alternately.
  task run_frame(bit extremes, bit count_it);
    int unsigned w, h, dh;
    logic [7:0] a, b, c;
    w = sb.eff_w(); h = sb.eff_h(); dh = sb.below_rows();
    for (int r = 0; r < h + dh; r++)
      for (int x = 0; x < w; x++) begin
        a = $urandom_range(0, 255); b = $urandom_range(0, 255); c = $urandom_range(0, 255);
        if (extremes) begin
          a = ((r + x) & 1) ? 8'hFF : 8'h00;
          b = ~a;
          c = (x & 1) ? 8'hFF : 8'h00;
        end
        if (r < h) begin
          if ($urandom_range(0, 9) == 0) send_item(1, c, b, a);
          send_item(0, a, b, c);
        end else begin
          send_item($urandom_range(0, 1), a, b, c);
        end
        if (count_it) random_items++;
      end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings untouched need a 640x480 frame, so set small
    configure(3, 2, 2, 3, 1);
    run_frame(1, 0);
    // zero written to the sizes: taken as 1
    configure(0, 0, 0, 0, 0);
    run_frame(1, 0);
    // kernels far wider than the image, gray mode
    configure(2, 3, 31, 31, 0);
    run_frame(1, 0);
    // wide single row, widest kernel: 16 results on the last column
    configure(40, 1, 31, 1, 1);
    run_frame(0, 0);
    // tall single column; over-range width value clamps too
    configure(4095, 1, 1, 1, 0);
    configure(1, 24, 1, 2, 0);
    run_frame(0, 0);

    // random frames; one early long receiver hold-off
    hold_req = 1;
    while (random_items < 215) begin
      if (random_items > 170) gaps_on = 0;  // closing stretch at full rate
      configure($urandom_range(1, 10), $urandom_range(1, 4),
                $urandom_range(1, 31), $urandom_range(1, 9), $urandom_range(0, 1));
      run_frame($urandom_range(0, 7) == 0, 1);
    end
    in_valid <= 0;

    wait_idle();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
